[design/assert_macros.svh]
// Assertion macros used by the note-off scheduler RTL.
// No dependencies; included by mnos_back, the one file that carries assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent implies consequent on the following clock edge.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[design/mnos_pkg.sv]
// Types and constants of the MIDI note-off scheduler.
// No dependencies; imported by the front, back and top-level modules.
package mnos_pkg;

  localparam int KEYS     = 128;
  localparam int KEY_W    = 7;
  localparam int CHAN_W   = 4;
  localparam int IN_CH_W  = 5;
  localparam int DUR_W    = 16;
  localparam int VEL_W    = 7;
  localparam int STATUS_W = 8;

  localparam logic [STATUS_W-1:0] NOTE_ON_BASE  = 8'd144;
  localparam logic [STATUS_W-1:0] NOTE_OFF_BASE = 8'd128;
  localparam logic [VEL_W-1:0]    VEL_RESET     = 7'd100;
  localparam logic [IN_CH_W-1:0]  TOP_CHANNEL   = 5'd15;
  localparam logic [KEY_W-1:0]    KEY_LAST      = 7'd127;

  localparam logic FUNC_PLAY = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef struct packed {
    logic              is_tick;
    logic [KEY_W-1:0]  note;
    logic [CHAN_W-1:0] chan;
    logic [DUR_W-1:0]  dur;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    key;
    logic [VEL_W-1:0]    vel;
    logic                last;
    logic                untracked;
  } msg_t;

endpackage

[design/mnos_fifo.sv]
// Small first-word-fall-through queue used between the scheduler stages.
// Generic; no package dependencies.
module mnos_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

[design/mnos_front.sv]
// Front stage: accepts input items, drops plays on channels above fifteen
// and hands the rest to the command queue. Depends on mnos_pkg.
module mnos_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             push,
  output logic                             full,
  input  logic                             func,
  input  logic [mnos_pkg::KEY_W-1:0]       note,
  input  logic [mnos_pkg::IN_CH_W-1:0]     chan,
  input  logic [mnos_pkg::DUR_W-1:0]       dur,
  output logic                             cmd_valid,
  output mnos_pkg::cmd_t                   cmd,
  input  logic                             cmd_ready
);

  import mnos_pkg::*;

  logic cmd_valid_r;
  cmd_t cmd_r;
  logic take, keep;

  assign full      = cmd_valid_r && !cmd_ready;
  assign take      = push && !full;
  assign keep      = (func == FUNC_TICK) || (chan <= TOP_CHANNEL);
  assign cmd_valid = cmd_valid_r;
  assign cmd       = cmd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_valid_r <= 1'b0;
    end else if (take) begin
      cmd_valid_r <= keep;
    end else if (cmd_ready) begin
      cmd_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd_r.is_tick <= (func == FUNC_TICK);
      cmd_r.note    <= note;
      cmd_r.chan    <= chan[CHAN_W-1:0];
      cmd_r.dur     <= dur;
    end
  end

endmodule

[design/mnos_back.sv]
// Back stage: note table indexed by note number, note-on issue and the
// tick scan that emits note-offs. Depends on mnos_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mnos_back #(
  parameter int SLOTS = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cmd_valid,
  input  mnos_pkg::cmd_t             cmd,
  output logic                       cmd_pop,
  input  logic                       out_full,
  output logic                       out_push,
  output mnos_pkg::msg_t             out_msg,
  input  logic [mnos_pkg::VEL_W-1:0] velocity
);

  import mnos_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_FLUSH = 3'b100
  } state_t;

  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(SLOTS);

  state_t            state_r, state_nxt;
  logic [KEYS-1:0]   valid_r, valid_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [KEY_W-1:0]  ev_key_r, ev_key_nxt;
  logic              pend_valid_r, pend_valid_nxt;
  logic [KEY_W-1:0]  pend_key_r, pend_key_nxt;
  logic [CHAN_W-1:0] pend_chan_r, pend_chan_nxt;

  logic [CHAN_W-1:0] chan_mem [KEYS];
  logic [DUR_W-1:0]  rem_mem  [KEYS];
  logic [CHAN_W-1:0] chan_rd_r;
  logic [DUR_W-1:0]  rem_rd_r;

  logic              rd_en, chan_we, rem_we;
  logic [KEY_W-1:0]  rd_addr, wr_addr;
  logic [CHAN_W-1:0] wr_chan;
  logic [DUR_W-1:0]  wr_rem;
  logic              hit, ev_valid, expired;

  always_ff @(posedge clk) begin
    if (chan_we) begin
      chan_mem[wr_addr] <= wr_chan;
    end
    if (rem_we) begin
      rem_mem[wr_addr] <= wr_rem;
    end
    if (rd_en) begin
      chan_rd_r <= chan_mem[rd_addr];
      rem_rd_r  <= rem_mem[rd_addr];
    end
  end

  assign hit      = valid_r[cmd.note];
  assign ev_valid = valid_r[ev_key_r];
  assign expired  = (rem_rd_r <= DUR_W'(1));

  always_comb begin
    state_nxt      = state_r;
    valid_nxt      = valid_r;
    count_nxt      = count_r;
    ev_key_nxt     = ev_key_r;
    pend_valid_nxt = pend_valid_r;
    pend_key_nxt   = pend_key_r;
    pend_chan_nxt  = pend_chan_r;
    cmd_pop        = 1'b0;
    out_push       = 1'b0;
    out_msg        = '0;
    rd_en          = 1'b0;
    rd_addr        = ev_key_r + 1'b1;
    chan_we        = 1'b0;
    rem_we         = 1'b0;
    wr_addr        = cmd.note;
    wr_chan        = cmd.chan;
    wr_rem         = cmd.dur;

    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid && !out_full) begin
          cmd_pop = 1'b1;
          if (cmd.is_tick) begin
            rd_en      = 1'b1;
            rd_addr    = '0;
            ev_key_nxt = '0;
            state_nxt  = S_SCAN;
          end else begin
            out_push       = 1'b1;
            out_msg.status = NOTE_ON_BASE + {{(STATUS_W-CHAN_W){1'b0}}, cmd.chan};
            out_msg.key    = cmd.note;
            out_msg.vel    = velocity;
            out_msg.last   = 1'b1;
            if (hit) begin
              // Known note: only the length restarts, the channel stays.
              rem_we = 1'b1;
            end else if (count_r != CNT_FULL) begin
              chan_we              = 1'b1;
              rem_we               = 1'b1;
              valid_nxt[cmd.note]  = 1'b1;
              count_nxt            = count_r + 1'b1;
            end else begin
              out_msg.untracked = 1'b1;
            end
          end
        end
      end
      S_SCAN: begin
        if (!out_full) begin
          rd_en      = 1'b1;
          ev_key_nxt = ev_key_r + 1'b1;
          if (ev_valid) begin
            if (expired) begin
              valid_nxt[ev_key_r] = 1'b0;
              count_nxt           = count_r - 1'b1;
              pend_valid_nxt      = 1'b1;
              pend_key_nxt        = ev_key_r;
              pend_chan_nxt       = chan_rd_r;
              // The previous note-off is now known not to be the last one.
              if (pend_valid_r) begin
                out_push       = 1'b1;
                out_msg.status = NOTE_OFF_BASE + {{(STATUS_W-CHAN_W){1'b0}}, pend_chan_r};
                out_msg.key    = pend_key_r;
              end
            end else begin
              rem_we  = 1'b1;
              wr_addr = ev_key_r;
              wr_rem  = rem_rd_r - 1'b1;
            end
          end
          if (ev_key_r == KEY_LAST) begin
            state_nxt = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        if (!pend_valid_r) begin
          state_nxt = S_IDLE;
        end else if (!out_full) begin
          out_push       = 1'b1;
          out_msg.status = NOTE_OFF_BASE + {{(STATUS_W-CHAN_W){1'b0}}, pend_chan_r};
          out_msg.key    = pend_key_r;
          out_msg.last   = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      valid_r      <= '0;
      count_r      <= '0;
      ev_key_r     <= '0;
      pend_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      valid_r      <= valid_nxt;
      count_r      <= count_nxt;
      ev_key_r     <= ev_key_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_key_r  <= pend_key_nxt;
    pend_chan_r <= pend_chan_nxt;
  end

  `ASSERT_AT(a_count_bound, clk, rst_n, count_r <= CNT_FULL, "note count above capacity")
  `ASSERT_AT(a_count_match, clk, rst_n, $countones(valid_r) == count_r, "note count out of step")
  `ASSERT_AT(a_push_room, clk, rst_n, !out_push || !out_full, "message pushed into full queue")
  `ASSERT_AT(a_idle_no_pend, clk, rst_n, state_r != S_IDLE || !pend_valid_r, "note-off left behind")

endmodule

[design/midi_note_off_scheduler_core.sv]
// Top level of the MIDI note-off scheduler: front stage, command queue,
// back stage, message queue and configuration register. Depends on mnos_pkg.
//
// Each transaction on the input side is a play or a tick. A play on a channel
// above fifteen is dropped; any other play produces one note-on (status 144
// plus channel, the configured velocity) and records the note with its length
// in a table of up to SLOTS notes, keyed by note number; a note already held
// only has its length restarted, and a play that finds the table full is
// sent with untracked set. A tick counts every held note down and emits a
// note-off (status 128 plus stored channel, velocity zero) for each one that
// runs out, in ascending note order, the final one marked with last_of_run.
// The back stage settles a play straight from its idle state; its note-on
// passes the front register, the command queue and the message queue on
// its way to the result ports. A tick walks all 128 note numbers, one per
// cycle while the message queue has room, through the single read port of
// the note table; the back stage takes no new command until the scan and
// any final note-off are done. Input and results are decoupled by a two-entry
// command queue and a two-entry message queue, so the input side keeps taking
// transactions, until the command queue fills, while finished messages wait.
module midi_note_off_scheduler_core #(
  parameter int SLOTS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic                          in_func,
  input  logic [mnos_pkg::KEY_W-1:0]    in_note_number,
  input  logic [mnos_pkg::IN_CH_W-1:0]  in_channel_number,
  input  logic [mnos_pkg::DUR_W-1:0]    in_duration_ticks,
  output logic                          empty,
  input  logic                          pop,
  output logic [mnos_pkg::STATUS_W-1:0] out_status_byte,
  output logic [mnos_pkg::KEY_W-1:0]    out_key_number,
  output logic [mnos_pkg::VEL_W-1:0]    out_velocity_byte,
  output logic                          out_last_of_run,
  output logic                          out_untracked,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  import mnos_pkg::*;

  // Register index sits in the word address bit; one register is defined.
  localparam logic REG_NOTE_ON_VELOCITY = 1'b0;
  localparam int   QDEPTH = 2;

  logic [VEL_W-1:0] note_on_velocity_r;
  logic             cfg_write;

  cmd_t                   front_cmd, back_cmd;
  logic                   front_valid, cmd_q_full, cmd_q_empty, cmd_pop;
  logic [$bits(cmd_t)-1:0] cmd_q_rdata;
  msg_t                   back_msg, out_msg;
  logic                   msg_push, msg_q_full;
  logic [$bits(msg_t)-1:0] msg_q_rdata;

  // Configuration: writes complete in the access phase; pready is tied high.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_NOTE_ON_VELOCITY) ?
                     {{(32-VEL_W){1'b0}}, note_on_velocity_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      note_on_velocity_r <= VEL_RESET;
    end else if (cfg_write && (paddr[2] == REG_NOTE_ON_VELOCITY)) begin
      note_on_velocity_r <= pwdata[VEL_W-1:0];
    end
  end

  // Front stage classifies each transaction and filters dropped plays.
  mnos_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .func      (in_func),
    .note      (in_note_number),
    .chan      (in_channel_number),
    .dur       (in_duration_ticks),
    .cmd_valid (front_valid),
    .cmd       (front_cmd),
    .cmd_ready (!cmd_q_full)
  );

  // Command queue lets the front keep accepting while a tick scan runs, until it fills.
  mnos_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (QDEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (front_valid),
    .wdata (front_cmd),
    .full  (cmd_q_full),
    .pop   (cmd_pop),
    .rdata (cmd_q_rdata),
    .empty (cmd_q_empty)
  );

  assign back_cmd = cmd_t'(cmd_q_rdata);

  // Back stage owns the note table and produces all messages.
  mnos_back #(
    .SLOTS (SLOTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (!cmd_q_empty),
    .cmd       (back_cmd),
    .cmd_pop   (cmd_pop),
    .out_full  (msg_q_full),
    .out_push  (msg_push),
    .out_msg   (back_msg),
    .velocity  (note_on_velocity_r)
  );

  // Message queue holds finished messages until the consumer pops them.
  mnos_fifo #(
    .WIDTH ($bits(msg_t)),
    .DEPTH (QDEPTH)
  ) u_msg_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (msg_push),
    .wdata (back_msg),
    .full  (msg_q_full),
    .pop   (pop),
    .rdata (msg_q_rdata),
    .empty (empty)
  );

  assign out_msg           = msg_t'(msg_q_rdata);
  assign out_status_byte   = out_msg.status;
  assign out_key_number    = out_msg.key;
  assign out_velocity_byte = out_msg.vel;
  assign out_last_of_run   = out_msg.last;
  assign out_untracked     = out_msg.untracked;

endmodule
